// ===== rtl/core/pec_pkg.sv =====
`default_nettype none
package pec_pkg;

  // Store geometry
  localparam int unsigned BUCKETS = 512;
  localparam int unsigned AW      = $clog2(BUCKETS);
  localparam int unsigned FILL_W  = $clog2(BUCKETS + 1);
  localparam int unsigned RAM_W   = 31;  // {high[14:0], low[15:0]}

  // Item commands
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_END    = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  // Phase codes, as shown on the mode output
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CAPT  = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;
  localparam logic [1:0] PH_DECAY = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_INIT_LEN  = 3'd0;
  localparam logic [2:0] REG_TRIGGER   = 3'd1;
  localparam logic [2:0] REG_SIL_LEVEL = 3'd2;
  localparam logic [2:0] REG_SIL_MS    = 3'd3;
  localparam logic [2:0] REG_HOLD_MS   = 3'd4;

  // Register reset values
  localparam logic [10:0] RST_INIT_LEN  = 11'd48;
  localparam logic [14:0] RST_TRIGGER   = 15'd49;
  localparam logic [14:0] RST_SIL_LEVEL = 15'd13;
  localparam logic [9:0]  RST_SIL_MS    = 10'd50;
  localparam logic [12:0] RST_HOLD_MS   = 13'd500;

  // Arithmetic constants
  localparam logic [14:0] HELD_REARM = 15'd655;        // 0.02
  localparam logic [15:0] GAIN_UNITY = 16'd4096;       // 1.0 in Q4.12
  localparam logic [14:0] FADE_FULL  = 15'd32767;
  localparam logic [15:0] GAIN_MIN   = 16'd41;         // 0.01
  localparam logic [15:0] GAIN_MAX   = 16'd57344;      // 14.0
  localparam logic [13:0] GAIN_STEP  = 14'd11796;      // 0.18 in Q0.16
  localparam int unsigned DIV_W      = 27;
  localparam logic [26:0] DIV_NUM    = 27'd115427901;  // 0.86 scaled
  localparam logic [29:0] DECAY_MUL  = 30'd1069455435; // exp(-0.004) in Q0.30
  localparam logic [14:0] FADE_IDLE  = 15'd492;        // 0.015
  localparam logic [6:0]  DELTA_MAX  = 7'd100;

  typedef struct packed {
    logic [10:0] init_len;
    logic [14:0] trigger;
    logic [14:0] sil_level;
    logic [9:0]  sil_ms;
    logic [12:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [15:0] sample;
    logic [14:0]        mag;
    logic               new_call;
    logic [14:0]        level;
    logic [6:0]         delta;
    logic [8:0]         index;
    logic               in_range;
  } op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         used;
    logic               partial;
    logic [15:0]        gain;
    logic [14:0]        opacity;
    logic [14:0]        high;
    logic signed [15:0] low;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/pec_ram.sv =====
`default_nettype none
module pec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/pec_front.sv =====
`default_nettype none
module pec_front import pec_pkg::*; (
  input  wire logic        [1:0]  command_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               new_call_i,
  input  wire logic        [14:0] level_i,
  input  wire logic        [6:0]  delta_ms_i,
  input  wire logic        [8:0]  index_i,
  output op_t                     op_o
);

  // Classify the transaction: magnitude, clamped delta, index range
  always_comb begin
    op_o          = '0;
    op_o.cmd      = cmd_e'(command_i);
    op_o.sample   = sample_i;
    if (sample_i[15]) begin
      op_o.mag = (sample_i == 16'sh8000) ? 15'h7fff : 15'(-sample_i);
    end else begin
      op_o.mag = sample_i[14:0];
    end
    op_o.new_call = new_call_i;
    op_o.level    = level_i;
    op_o.delta    = (delta_ms_i > DELTA_MAX) ? DELTA_MAX : delta_ms_i;
    op_o.index    = index_i;
    op_o.in_range = (32'(index_i) < BUCKETS);
  end

endmodule
`default_nettype wire

// ===== rtl/core/pec_queue.sv =====
`default_nettype none
module pec_queue import pec_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  op_t       data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       data_o
);

  op_t        slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];

endmodule
`default_nettype wire

// ===== rtl/core/pec_back.sv =====
`default_nettype none
module pec_back import pec_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  output logic      init_busy_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  localparam logic [4:0] ST_WAIT      = 5'd0;
  localparam logic [4:0] ST_CLR       = 5'd1;
  localparam logic [4:0] ST_CMP_RD0   = 5'd2;
  localparam logic [4:0] ST_CMP_RD1   = 5'd3;
  localparam logic [4:0] ST_CMP_WR    = 5'd4;
  localparam logic [4:0] ST_CMP_CLR   = 5'd5;
  localparam logic [4:0] ST_SMP_RD    = 5'd6;
  localparam logic [4:0] ST_SMP_WR    = 5'd7;
  localparam logic [4:0] ST_DIV       = 5'd8;
  localparam logic [4:0] ST_GAIN_MUL  = 5'd9;
  localparam logic [4:0] ST_GAIN_ADD  = 5'd10;
  localparam logic [4:0] ST_DEC_M0    = 5'd11;
  localparam logic [4:0] ST_DEC_M1    = 5'd12;
  localparam logic [4:0] ST_DEC_MUL   = 5'd13;
  localparam logic [4:0] ST_DEC_APPLY = 5'd14;
  localparam logic [4:0] ST_RD        = 5'd15;
  localparam logic [4:0] ST_DONE      = 5'd16;

  logic [4:0]         st_q;
  logic               init_q;
  logic [AW-1:0]      cnt_q;
  logic [FILL_W-1:0]  filled_q;
  logic [31:0]        fill_q;
  logic [31:0]        len_q;
  logic [14:0]        held_q;
  logic [14:0]        batch_q;
  logic [15:0]        gain_q;
  logic [14:0]        fade_q;
  logic [15:0]        silent_q;
  logic [15:0]        hold_q;
  logic [1:0]         phase_q;
  logic [RAM_W-1:0]   pair_q;
  logic signed [15:0] smp_q;
  logic [14:0]        smp_mag_q;
  logic [DIV_W-1:0]   num_q;
  logic [DIV_W-1:0]   quo_q;
  logic [14:0]        rem_q;
  logic [14:0]        dvs_q;
  logic [4:0]         bit_q;
  logic [29:0]        gprod_q;
  logic [30:0]        f_q;
  logic [45:0]        acc_q;
  logic [6:0]         k_q;
  logic [31:0]        fprod_q;
  logic [14:0]        res_hi_q;
  logic signed [15:0] res_lo_q;
  logic               out_valid_q;
  res_t               res_q;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [RAM_W-1:0]   wdata;
  logic [AW-1:0]      raddr;
  logic [RAM_W-1:0]   rdata;

  logic [14:0]        rd_hi;
  logic signed [15:0] rd_lo;
  logic [14:0]        pr_hi;
  logic signed [15:0] pr_lo;
  logic [14:0]        mg_hi;
  logic signed [15:0] mg_lo;
  logic [14:0]        up_hi;
  logic signed [15:0] up_lo;
  logic               rearm;
  logic [14:0]        held_new;
  logic [16:0]        sil_sum;
  logic [15:0]        sil_new;
  logic [16:0]        hold_sum;
  logic [15:0]        hold_new;
  logic [15:0]        rem_sh;
  logic               qbit;
  logic [15:0]        target;
  logic [61:0]        dsum;
  logic [16:0]        f16;
  logic [14:0]        fade_new;
  logic [32:0]        fill_sum;
  logic [31:0]        len_dbl;

  pec_ram #(
    .WIDTH(RAM_W),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign op_pop_o    = (st_q == ST_WAIT) && op_valid_i && !out_valid_q;
  assign init_busy_o = init_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    rd_hi = rdata[30:16];
    rd_lo = rdata[15:0];
    pr_hi = pair_q[30:16];
    pr_lo = pair_q[15:0];
    mg_hi = (pr_hi > rd_hi) ? pr_hi : rd_hi;
    mg_lo = (pr_lo < rd_lo) ? pr_lo : rd_lo;
    up_hi = (smp_q > 16'sd0 && smp_q[14:0] > rd_hi) ? smp_q[14:0] : rd_hi;
    up_lo = (smp_q < rd_lo) ? smp_q : rd_lo;

    rearm    = op_i.new_call || (phase_q == PH_IDLE && op_i.level >= cfg_i.trigger);
    held_new = (batch_q > held_q) ? batch_q : held_q;
    sil_sum  = 17'(silent_q) + 17'(op_i.delta);
    if (batch_q < cfg_i.sil_level) begin
      sil_new = sil_sum[16] ? 16'hffff : sil_sum[15:0];
    end else begin
      sil_new = 16'd0;
    end
    hold_sum = 17'(hold_q) + 17'(op_i.delta);
    hold_new = hold_sum[16] ? 16'hffff : hold_sum[15:0];

    rem_sh = {rem_q, num_q[DIV_W-1]};
    qbit   = (rem_sh >= 16'(dvs_q));

    if (quo_q < DIV_W'(GAIN_MIN)) begin
      target = GAIN_MIN;
    end else if (quo_q > DIV_W'(GAIN_MAX)) begin
      target = GAIN_MAX;
    end else begin
      target = 16'(quo_q);
    end

    dsum     = 62'(acc_q) + (62'(46'(f_q) * 46'(DECAY_MUL[29:15])) << 15) + 62'(32'd1 << 29);
    f16      = 17'((32'(f_q) + 32'd8192) >> 14);
    fade_new = 15'((33'(fprod_q) + 33'd32768) >> 16);
    fill_sum = 33'(fill_q) + 33'd1;
    len_dbl  = len_q[31] ? 32'hffff_ffff : {len_q[30:0], 1'b0};

    raddr = '0;
    we    = 1'b0;
    waddr = cnt_q;
    wdata = '0;
    case (st_q)
      ST_WAIT:    raddr = AW'(op_i.index);
      ST_CMP_RD0: raddr = {cnt_q[AW-2:0], 1'b0};
      ST_CMP_RD1: raddr = {cnt_q[AW-2:0], 1'b1};
      ST_SMP_RD:  raddr = filled_q[AW-1:0];
      ST_CLR, ST_CMP_CLR: begin
        we = 1'b1;
      end
      ST_CMP_WR: begin
        we    = 1'b1;
        wdata = {mg_hi, mg_lo};
      end
      ST_SMP_WR: begin
        we    = 1'b1;
        waddr = filled_q[AW-1:0];
        wdata = {up_hi, up_lo};
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      filled_q    <= '0;
      fill_q      <= '0;
      len_q       <= 32'd1;
      held_q      <= '0;
      batch_q     <= '0;
      gain_q      <= GAIN_UNITY;
      fade_q      <= FADE_FULL;
      silent_q    <= '0;
      hold_q      <= '0;
      phase_q     <= PH_IDLE;
      pair_q      <= '0;
      smp_q       <= '0;
      smp_mag_q   <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      bit_q       <= '0;
      gprod_q     <= '0;
      f_q         <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      fprod_q     <= '0;
      res_hi_q    <= '0;
      res_lo_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_WAIT: begin
          if (op_pop_o) begin
            res_hi_q <= '0;
            res_lo_q <= '0;
            case (op_i.cmd)
              CMD_BEGIN: begin
                batch_q <= '0;
                if (rearm) begin
                  filled_q <= '0;
                  fill_q   <= '0;
                  len_q    <= (cfg_i.init_len == 11'd0) ? 32'd1 : 32'(cfg_i.init_len);
                  held_q   <= HELD_REARM;
                  gain_q   <= GAIN_UNITY;
                  fade_q   <= FADE_FULL;
                  silent_q <= '0;
                  hold_q   <= '0;
                  phase_q  <= PH_CAPT;
                  cnt_q    <= '0;
                  st_q     <= ST_CLR;
                end else begin
                  st_q <= ST_DONE;
                end
              end
              CMD_SAMPLE: begin
                smp_q     <= op_i.sample;
                smp_mag_q <= op_i.mag;
                if (phase_q == PH_CAPT) begin
                  if (32'(filled_q) >= BUCKETS) begin
                    cnt_q <= '0;
                    st_q  <= ST_CMP_RD0;
                  end else begin
                    st_q <= ST_SMP_RD;
                  end
                end else begin
                  st_q <= ST_DONE;
                end
              end
              CMD_END: begin
                batch_q <= '0;
                case (phase_q)
                  PH_CAPT: begin
                    held_q   <= held_new;
                    silent_q <= sil_new;
                    if (sil_new >= 16'(cfg_i.sil_ms)) begin
                      phase_q <= PH_HOLD;
                      hold_q  <= '0;
                    end
                    if (held_new == 15'd0) begin
                      quo_q <= DIV_W'(GAIN_MAX);
                      st_q  <= ST_GAIN_MUL;
                    end else begin
                      num_q <= DIV_NUM + DIV_W'(held_new >> 1);
                      quo_q <= '0;
                      rem_q <= '0;
                      dvs_q <= held_new;
                      bit_q <= '0;
                      st_q  <= ST_DIV;
                    end
                  end
                  PH_HOLD: begin
                    hold_q <= hold_new;
                    if (hold_new >= 16'(cfg_i.hold_ms)) begin
                      phase_q <= PH_DECAY;
                    end
                    st_q <= ST_DONE;
                  end
                  PH_DECAY: begin
                    f_q <= 31'(32'd1 << 30);
                    k_q <= op_i.delta;
                    st_q <= (op_i.delta == 7'd0) ? ST_DEC_MUL : ST_DEC_M0;
                  end
                  default: st_q <= ST_DONE;
                endcase
              end
              CMD_READ: begin
                if (op_i.in_range) begin
                  st_q <= ST_RD;
                end else begin
                  st_q <= ST_DONE;
                end
              end
              default: st_q <= ST_DONE;
            endcase
          end
        end
        ST_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(BUCKETS - 1)) begin
            if (init_q) begin
              init_q <= 1'b0;
              st_q   <= ST_WAIT;
            end else begin
              st_q <= ST_DONE;
            end
          end
        end
        ST_CMP_RD0: st_q <= ST_CMP_RD1;
        ST_CMP_RD1: begin
          pair_q <= rdata;
          st_q   <= ST_CMP_WR;
        end
        ST_CMP_WR: begin
          cnt_q <= cnt_q + 1'b1;
          st_q  <= (cnt_q == AW'(BUCKETS / 2 - 1)) ? ST_CMP_CLR : ST_CMP_RD0;
        end
        ST_CMP_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(BUCKETS - 1)) begin
            filled_q <= FILL_W'(BUCKETS / 2);
            len_q    <= len_dbl;
            st_q     <= ST_SMP_RD;
          end
        end
        ST_SMP_RD: st_q <= ST_SMP_WR;
        ST_SMP_WR: begin
          if (smp_mag_q > batch_q) begin
            batch_q <= smp_mag_q;
          end
          if (fill_sum >= 33'(len_q)) begin
            filled_q <= filled_q + 1'b1;
            fill_q   <= '0;
          end else begin
            fill_q <= fill_sum[31:0];
          end
          st_q <= ST_DONE;
        end
        ST_DIV: begin
          rem_q <= qbit ? 15'(rem_sh - 16'(dvs_q)) : rem_sh[14:0];
          quo_q <= {quo_q[DIV_W-2:0], qbit};
          num_q <= {num_q[DIV_W-2:0], 1'b0};
          bit_q <= bit_q + 1'b1;
          if (bit_q == 5'(DIV_W - 1)) begin
            st_q <= ST_GAIN_MUL;
          end
        end
        ST_GAIN_MUL: begin
          if (target < gain_q) begin
            gain_q <= target;
            st_q   <= ST_DONE;
          end else begin
            gprod_q <= 30'(target - gain_q) * 30'(GAIN_STEP);
            st_q    <= ST_GAIN_ADD;
          end
        end
        ST_GAIN_ADD: begin
          gain_q <= gain_q + 16'((31'(gprod_q) + 31'd32768) >> 16);
          st_q   <= ST_DONE;
        end
        ST_DEC_M0: begin
          acc_q <= 46'(f_q) * 46'(DECAY_MUL[14:0]);
          st_q  <= ST_DEC_M1;
        end
        ST_DEC_M1: begin
          f_q <= 31'(dsum >> 30);
          k_q <= k_q - 1'b1;
          st_q <= (k_q == 7'd1) ? ST_DEC_MUL : ST_DEC_M0;
        end
        ST_DEC_MUL: begin
          fprod_q <= 32'(fade_q) * 32'(f16);
          st_q    <= ST_DEC_APPLY;
        end
        ST_DEC_APPLY: begin
          fade_q <= fade_new;
          if (fade_new < FADE_IDLE) begin
            phase_q  <= PH_IDLE;
            filled_q <= '0;
          end
          st_q <= ST_DONE;
        end
        ST_RD: begin
          res_hi_q <= rd_hi;
          res_lo_q <= rd_lo;
          st_q     <= ST_DONE;
        end
        ST_DONE: begin
          res_q.mode    <= phase_q;
          res_q.used    <= 10'(filled_q);
          res_q.partial <= (fill_q != 32'd0);
          res_q.gain    <= gain_q;
          res_q.opacity <= fade_q;
          res_q.high    <= res_hi_q;
          res_q.low     <= res_lo_q;
          out_valid_q   <= 1'b1;
          st_q          <= ST_WAIT;
        end
        default: st_q <= ST_WAIT;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/peak_envelope_capture.sv =====
// Min/max peak envelope capture. Transactions arrive framed as begin, samples,
// end; read transactions fetch one bucket, and every transaction returns one
// result showing mode, used buckets, gain, opacity and (for reads) the bucket.
// A front stage classifies each transaction into a two-entry queue; the back
// engine carries it out against a two-port bucket RAM (one write and one
// registered read per cycle) and parks the result in an output register. The
// engine takes no new transaction while a result waits, but the queue keeps
// taking input until it is full. A sample that finds the store full first
// compacts it, pair by pair through the single RAM read port; an end while
// capturing runs the bit-serial gain divider (27 steps); an end while decaying
// runs the two-pass decay multiplier once per clamped delta_ms; a re-arm runs
// the clearing sweep of the store. After reset the store is swept clear and no
// transaction is taken until the sweep ends; configuration writes are always
// taken.
`default_nettype none
module peak_envelope_capture import pec_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [1:0]  command_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               new_call_i,
  input  wire logic        [14:0] level_i,
  input  wire logic        [6:0]  delta_ms_i,
  input  wire logic        [8:0]  index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic             [1:0]  mode_o,
  output logic             [9:0]  used_buckets_o,
  output logic                    partial_bucket_o,
  output logic             [15:0] gain_o,
  output logic             [14:0] opacity_o,
  output logic             [14:0] bucket_high_o,
  output logic signed      [15:0] bucket_low_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [2:0]  cfg_index_i,
  input  wire logic        [15:0] cfg_data_i
);

  cfg_t cfg_q;
  op_t  front_op;
  op_t  queue_op;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;
  logic init_busy;
  logic push;
  res_t res;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_len  <= RST_INIT_LEN;
      cfg_q.trigger   <= RST_TRIGGER;
      cfg_q.sil_level <= RST_SIL_LEVEL;
      cfg_q.sil_ms    <= RST_SIL_MS;
      cfg_q.hold_ms   <= RST_HOLD_MS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_INIT_LEN:  cfg_q.init_len  <= cfg_data_i[10:0];
        REG_TRIGGER:   cfg_q.trigger   <= cfg_data_i[14:0];
        REG_SIL_LEVEL: cfg_q.sil_level <= cfg_data_i[14:0];
        REG_SIL_MS:    cfg_q.sil_ms    <= cfg_data_i[9:0];
        REG_HOLD_MS:   cfg_q.hold_ms   <= cfg_data_i[12:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  // Hold off input while the queue is full or the store is still being cleared
  assign in_stall_o = queue_full || init_busy;
  assign push       = in_valid_i && !in_stall_o;

  pec_front u_front (
    .command_i (command_i),
    .sample_i  (sample_i),
    .new_call_i(new_call_i),
    .level_i   (level_i),
    .delta_ms_i(delta_ms_i),
    .index_i   (index_i),
    .op_o      (front_op)
  );

  pec_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_op),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .data_o (queue_op)
  );

  pec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (queue_valid),
    .op_i       (queue_op),
    .op_pop_o   (queue_pop),
    .init_busy_o(init_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign mode_o           = res.mode;
  assign used_buckets_o   = res.used;
  assign partial_bucket_o = res.partial;
  assign gain_o           = res.gain;
  assign opacity_o        = res.opacity;
  assign bucket_high_o    = res.high;
  assign bucket_low_o     = res.low;

endmodule
`default_nettype wire

// ===== rtl/core/pec_checker.sv =====
`default_nettype none
module pec_checker import pec_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire logic        [1:0]  mode_i,
  input wire logic        [9:0]  used_buckets_i,
  input wire logic        [15:0] gain_i,
  input wire logic signed [15:0] bucket_low_i,
  input wire logic               cfg_ready_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(gain_i) && $stable(mode_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gain_i <= GAIN_MAX)
    else $error("gain above clamp");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(used_buckets_i) <= BUCKETS)
    else $error("used buckets beyond store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bucket_low_i <= 16'sd0 && cfg_ready_i)
    else $error("bucket low positive or config not ready");

endmodule

bind peak_envelope_capture pec_checker u_pec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mode_i        (mode_o),
  .used_buckets_i(used_buckets_o),
  .gain_i        (gain_o),
  .bucket_low_i  (bucket_low_o),
  .cfg_ready_i   (cfg_ready_o)
);
`default_nettype wire
